// ===== rtl/core/sstq_pkg.sv =====
// Shared types and codes for the sorted session timer queue.
package sstq_pkg;

    localparam int unsigned CD_W   = 16;
    localparam int unsigned BYTE_W = 8;

    // Operation codes carried on the func field
    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_INSERT = 3'd1,
        FN_TICK   = 3'd2,
        FN_SEARCH = 3'd3,
        FN_POP    = 3'd4,
        FN_CROP   = 3'd5,
        FN_DROP   = 3'd6
    } t_func;

    // Per-cell load select
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_NEW,
        SEL_LOWER,
        SEL_UPPER,
        SEL_TICK
    } t_sel;

    // One session entry, 48 bits
    typedef struct packed {
        logic [CD_W-1:0]   cd;
        logic [BYTE_W-1:0] chan;
        logic [BYTE_W-1:0] net;
        logic [BYTE_W-1:0] app;
        logic [BYTE_W-1:0] dlg;
    } t_entry;

    // Per-cell compare results, taken against the current entry
    typedef struct packed {
        logic smaller;   // newcomer countdown is nonzero and larger than this one
        logic le_lim;    // countdown at or below crop limit
        logic nonzero;   // countdown not zero
        logic chan_hit;  // channel equals queried channel
        logic expired;   // countdown after tick is zero
    } t_cell_flags;

endpackage

// ===== rtl/core/sorted_session_timer_queue_core.sv =====
// Top level of the sorted session timer queue: cell row, control and result register.
//
// Sorted session timer queue. Holds up to TABLE_DEPTH sessions in a row of
// cells kept sorted by countdown: cell 0 is the furthest session, the cell at
// entry_count-1 is the top (soonest). Each input beat carries one operation
// (clear, insert, tick, channel search, pop, crop, drop) and yields exactly one
// output beat with the operation's flags, the entry count and the top entry's
// fields (all zero when the table is empty). An insert places the newcomer
// above equal countdowns, a zero countdown always on top; a full table evicts
// cell 0 or rejects a newcomer that would be furthest. Tick saturates at zero.
// Crop pops every top entry at or below crop_limit; drop removes the top while
// the entry below it has expired, never emptying the table. Func 7 only
// reports status. Timing: the result of a taken beat sits in the output
// register from the next cycle on, and a new beat is taken in the same cycle
// that the previous result is taken, so the block sustains one beat per cycle
// while results are taken. The cycle path is set by the per-cell countdown
// compare, the popcount of the cell flags that places the newcomer, and the
// mux that picks the new top entry out of the row.
module sorted_session_timer_queue_core #(
    parameter int unsigned TABLE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_new_countdown,
    input  logic [7:0]  i_new_net_state,
    input  logic [7:0]  i_new_chan,
    input  logic [7:0]  i_new_app,
    input  logic [7:0]  i_new_dialog,
    input  logic [15:0] i_elapsed_ticks,
    input  logic [15:0] i_crop_limit,
    input  logic [7:0]  i_query_chan,
    // output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_any_expired,
    output logic        o_chan_busy,
    output logic        o_stored,
    output logic        o_evicted,
    output logic [2:0]  o_entry_count,
    output logic [15:0] o_top_countdown,
    output logic [7:0]  o_top_chan,
    output logic [7:0]  o_top_net_state,
    output logic [7:0]  o_top_app,
    output logic [7:0]  o_top_dialog
);

    // count holds 0..TABLE_DEPTH, index 0..TABLE_DEPTH-1
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic w_fire;

    assign o_ready = !r_out_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    // ---------------- cell row ----------------
    sstq_pkg::t_entry      w_new;
    sstq_pkg::t_entry      w_cur   [TABLE_DEPTH];
    sstq_pkg::t_entry      w_nxt   [TABLE_DEPTH];
    sstq_pkg::t_cell_flags w_flags [TABLE_DEPTH];
    sstq_pkg::t_sel        w_sel   [TABLE_DEPTH];

    assign w_new.cd   = i_new_countdown;
    assign w_new.chan = i_new_chan;
    assign w_new.net  = i_new_net_state;
    assign w_new.app  = i_new_app;
    assign w_new.dlg  = i_new_dialog;

    // Each cell loads from the one below (shift toward the top) or the one
    // above (shift toward cell 0 on eviction). Row ends take the new entry;
    // those paths are never selected.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sstq_pkg::t_entry w_lower_src;
        sstq_pkg::t_entry w_upper_src;

        if (g == 0) begin : g_first
            assign w_lower_src = w_new;
        end else begin : g_mid_lo
            assign w_lower_src = w_cur[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_upper_src = w_new;
        end else begin : g_mid_hi
            assign w_upper_src = w_cur[g+1];
        end

        sstq_cell u_cell (
            .i_clk        (i_clk),
            .i_sel        (w_sel[g]),
            .i_new        (w_new),
            .i_lower      (w_lower_src),
            .i_upper      (w_upper_src),
            .i_elapsed    (i_elapsed_ticks),
            .i_crop_limit (i_crop_limit),
            .i_query_chan (i_query_chan),
            .o_entry      (w_cur[g]),
            .o_next       (w_nxt[g]),
            .o_flags      (w_flags[g])
        );
    end

    // ---------------- flag reduction over held cells ----------------
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_n_smaller;
    logic [CW-1:0] w_n_above_lim;
    logic [CW-1:0] w_n_nonzero;
    logic          w_any_hit;
    logic          w_any_exp;

    always_comb begin
        w_n_smaller   = '0;
        w_n_above_lim = '0;
        w_n_nonzero   = '0;
        w_any_hit     = 1'b0;
        w_any_exp     = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CW'(i) < r_count) begin
                w_n_smaller   = w_n_smaller   + CW'(w_flags[i].smaller);
                w_n_above_lim = w_n_above_lim + CW'(!w_flags[i].le_lim);
                w_n_nonzero   = w_n_nonzero   + CW'(w_flags[i].nonzero);
                w_any_hit     = w_any_hit | w_flags[i].chan_hit;
                w_any_exp     = w_any_exp | w_flags[i].expired;
            end
        end
    end

    // ---------------- operation control ----------------
    sstq_pkg::t_func w_func;
    logic [CW-1:0]   w_pos;      // slot of newcomer in a non-full table
    logic [CW-1:0]   w_pos_m1;   // slot of newcomer after eviction
    logic            w_full;

    assign w_func   = sstq_pkg::t_func'(i_func);
    assign w_pos    = r_count - w_n_smaller;
    assign w_pos_m1 = w_pos - CW'(1);
    assign w_full   = (r_count == CW'(TABLE_DEPTH));

    always_comb begin
        logic [CW-1:0] ci;
        ci = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ci       = CW'(i);
            w_sel[i] = sstq_pkg::SEL_HOLD;
            if (w_fire) begin
                priority if (w_func == sstq_pkg::FN_TICK) begin
                    w_sel[i] = sstq_pkg::SEL_TICK;
                end else if (w_func == sstq_pkg::FN_INSERT && !w_full) begin
                    // open a slot at w_pos, push the nearer entries up
                    if (ci == w_pos) begin
                        w_sel[i] = sstq_pkg::SEL_NEW;
                    end else if (ci > w_pos && ci <= r_count) begin
                        w_sel[i] = sstq_pkg::SEL_LOWER;
                    end
                end else if (w_func == sstq_pkg::FN_INSERT && w_pos != '0) begin
                    // full: cell 0 falls out, further entries move down
                    if (ci == w_pos_m1) begin
                        w_sel[i] = sstq_pkg::SEL_NEW;
                    end else if (ci < w_pos_m1) begin
                        w_sel[i] = sstq_pkg::SEL_UPPER;
                    end
                end else begin
                    w_sel[i] = sstq_pkg::SEL_HOLD;
                end
            end
        end
    end

    // next count and per-op flags
    logic n_any_expired;
    logic n_chan_busy;
    logic n_stored;
    logic n_evicted;

    always_comb begin
        n_count       = r_count;
        n_any_expired = 1'b0;
        n_chan_busy   = 1'b0;
        n_stored      = 1'b0;
        n_evicted     = 1'b0;
        unique case (w_func)
            sstq_pkg::FN_CLEAR: begin
                n_count = '0;
            end
            sstq_pkg::FN_INSERT: begin
                if (!w_full) begin
                    n_count  = r_count + CW'(1);
                    n_stored = 1'b1;
                end else if (w_pos != '0) begin
                    n_stored  = 1'b1;
                    n_evicted = 1'b1;
                end
            end
            sstq_pkg::FN_TICK: begin
                n_any_expired = w_any_exp;
            end
            sstq_pkg::FN_SEARCH: begin
                n_chan_busy = w_any_hit;
            end
            sstq_pkg::FN_POP: begin
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end
            sstq_pkg::FN_CROP: begin
                // table is sorted, so what stays is exactly the entries above the limit
                n_count = w_n_above_lim;
            end
            sstq_pkg::FN_DROP: begin
                // expired entries form the top run; keep one of them
                if (w_n_nonzero < r_count) begin
                    n_count = w_n_nonzero + CW'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // top entry after the operation
    sstq_pkg::t_entry n_top;
    logic [CW-1:0]    w_top_idx;

    assign w_top_idx = n_count - CW'(1);

    always_comb begin
        if (n_count == '0) begin
            n_top = '0;
        end else begin
            n_top = w_nxt[w_top_idx[IW-1:0]];
        end
    end

    // ---------------- state and result register ----------------
    logic             r_any_expired;
    logic             r_chan_busy;
    logic             r_stored;
    logic             r_evicted;
    logic [2:0]       r_entry_count;
    sstq_pkg::t_entry r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_any_expired <= n_any_expired;
            r_chan_busy   <= n_chan_busy;
            r_stored      <= n_stored;
            r_evicted     <= n_evicted;
            r_entry_count <= 3'(n_count);
            r_top         <= n_top;
        end
    end

    assign o_any_expired   = r_any_expired;
    assign o_chan_busy     = r_chan_busy;
    assign o_stored        = r_stored;
    assign o_evicted       = r_evicted;
    assign o_entry_count   = r_entry_count;
    assign o_top_countdown = r_top.cd;
    assign o_top_chan      = r_top.chan;
    assign o_top_net_state = r_top.net;
    assign o_top_app       = r_top.app;
    assign o_top_dialog    = r_top.dlg;

    // ---------------- assertions ----------------
    logic w_sorted;

    always_comb begin
        w_sorted = 1'b1;
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (CW'(i) < r_count && w_cur[i].cd > w_cur[i-1].cd) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("held count beyond table depth");

    a_row_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sorted)
        else $error("held entries out of countdown order");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count == 3'(r_count)))
        else $error("reported count differs from held count");

    a_evict_implies_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> o_stored)
        else $error("eviction without store");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_any_expired, o_chan_busy, o_stored}))
        else $error("flags from more than one operation");

endmodule

// ===== rtl/core/sstq_cell.sv =====
// One table cell: holds an entry, compares it and loads from a neighbor, the new entry or its tick.
module sstq_cell (
    input  logic                  i_clk,
    input  sstq_pkg::t_sel        i_sel,
    input  sstq_pkg::t_entry      i_new,
    input  sstq_pkg::t_entry      i_lower,
    input  sstq_pkg::t_entry      i_upper,
    input  logic [15:0]           i_elapsed,
    input  logic [15:0]           i_crop_limit,
    input  logic [7:0]            i_query_chan,
    output sstq_pkg::t_entry      o_entry,
    output sstq_pkg::t_entry      o_next,
    output sstq_pkg::t_cell_flags o_flags
);

    sstq_pkg::t_entry r_entry;
    sstq_pkg::t_entry n_entry;
    logic [15:0]      w_tick_cd;

    // saturating subtract
    assign w_tick_cd = (r_entry.cd <= i_elapsed) ? 16'd0 : (r_entry.cd - i_elapsed);

    always_comb begin
        n_entry = r_entry;
        unique case (i_sel)
            sstq_pkg::SEL_HOLD:  n_entry = r_entry;
            sstq_pkg::SEL_NEW:   n_entry = i_new;
            sstq_pkg::SEL_LOWER: n_entry = i_lower;
            sstq_pkg::SEL_UPPER: n_entry = i_upper;
            sstq_pkg::SEL_TICK:  n_entry.cd = w_tick_cd;
            default:             n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        o_flags.smaller  = (i_new.cd != 16'd0) && (i_new.cd > r_entry.cd);
        o_flags.le_lim   = (r_entry.cd <= i_crop_limit);
        o_flags.nonzero  = (r_entry.cd != 16'd0);
        o_flags.chan_hit = (r_entry.chan == i_query_chan);
        o_flags.expired  = (w_tick_cd == 16'd0);
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule
